// ----- sv/disc_sector_extent_mapper_assert.svh -----
// Assertion macros shared by the checker of the disc sector extent mapper.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DISC_SECTOR_EXTENT_MAPPER_ASSERT_SVH
`define DISC_SECTOR_EXTENT_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DSEM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DSEM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dsem_pkg.sv -----
// Shared types and constants of the disc sector extent mapper.
// No dependencies; used by the controller, datapath, top level and checker.
package dsem_pkg;

  localparam int MaxEntriesDefault = 256;

  // Fixed sector layout of the disc image.
  localparam logic [31:0] SectPvd   = 32'd16;
  localparam logic [31:0] SectTerm  = 32'd17;
  localparam logic [31:0] SectPathL = 32'd18;
  localparam logic [31:0] SectPathM = 32'd19;
  localparam logic [31:0] SectDir0  = 32'd20;
  localparam int          SectShift = 11;
  localparam logic [31:0] SectMask  = 32'd2047;
  localparam logic [29:0] Cap30     = 30'h3FFF_FFFF;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Region codes.
  localparam logic [2:0] REGION_ZEROS  = 3'd0;
  localparam logic [2:0] REGION_PVD    = 3'd1;
  localparam logic [2:0] REGION_TERM   = 3'd2;
  localparam logic [2:0] REGION_PATH_L = 3'd3;
  localparam logic [2:0] REGION_PATH_M = 3'd4;
  localparam logic [2:0] REGION_DIR    = 3'd5;
  localparam logic [2:0] REGION_FILE   = 3'd6;
  localparam logic [2:0] REGION_BEYOND = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_dir;
    logic [31:0] size_bytes;
    logic [31:0] sector_addr;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  region;
    logic [7:0]  entry_index;
    logic [20:0] file_offset;
    logic [29:0] image_size;
  } rsp_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic        is_dir;
    logic [29:0] start;
    logic [21:0] len;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic last;
  } dp_status_t;

endpackage

// ----- sv/dsem_ctrl.sv -----
// Controller of the disc sector extent mapper: accepts transactions and
// sequences the table scan. Depends on dsem_pkg.
module dsem_ctrl import dsem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept = (state == ST_IDLE) && start;
    cmd.scan   = (state == ST_SCAN);
    cmd.finish = (state == ST_SCAN) && (status.hit || status.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= start && !status.need_scan;
          if (start && status.need_scan) begin
            state <= ST_SCAN;
            busy  <= 1'b1;
          end
        end
        ST_SCAN: begin
          done <= cmd.finish;
          if (cmd.finish) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/dsem_datapath.sv -----
// Datapath of the disc sector extent mapper: entry memory, counters, region
// decode, scan compare and result register. Depends on dsem_pkg.
module dsem_datapath import dsem_pkg::*; #(
  parameter int MaxEntries = MaxEntriesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  req_t       request,
  output dp_status_t status,
  output rsp_t       result
);

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxEntries);
  localparam entry_t RootEntry = '{is_dir: 1'b1, start: 30'd0, len: 22'd1};

  entry_t mem [MaxEntries];

  logic [CntW-1:0] entries_used;
  logic [CntW-1:0] dirs_used;
  logic [29:0]     file_span;

  logic            res_status;
  logic [2:0]      res_region;
  logic [7:0]      res_index;
  logic [20:0]     res_offset;

  logic [29:0]     key;
  logic            key_is_dir;
  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] rd_idx;
  logic            rd_vld;
  entry_t          rdata;

  logic [30:0]     total_sum;
  logic [29:0]     total_sat;
  logic [30:0]     file_base;
  logic [2:0]      lk_region;
  logic [21:0]     new_len;
  logic [30:0]     fs_sum;
  logic [29:0]     fs_next;
  logic            full;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] last_idx;
  logic            wr_en;
  entry_t          wr_data;
  entry_t          cur;
  logic [30:0]     diff;
  logic            hit_dir;
  logic            hit_file;

  // Image size and where file data begins.
  assign total_sum = 31'(SectDir0) + 31'(dirs_used) + 31'(file_span);
  assign total_sat = (total_sum > 31'(Cap30)) ? Cap30 : total_sum[29:0];
  assign file_base = 31'(SectDir0) + 31'(dirs_used);

  always_comb begin
    if (request.sector_addr < SectPvd)                    lk_region = REGION_ZEROS;
    else if (request.sector_addr == SectPvd)              lk_region = REGION_PVD;
    else if (request.sector_addr == SectTerm)             lk_region = REGION_TERM;
    else if (request.sector_addr == SectPathL)            lk_region = REGION_PATH_L;
    else if (request.sector_addr == SectPathM)            lk_region = REGION_PATH_M;
    else if (request.sector_addr < 32'(file_base))        lk_region = REGION_DIR;
    else if (request.sector_addr < 32'(total_sat))        lk_region = REGION_FILE;
    else                                                  lk_region = REGION_BEYOND;
  end

  // A file takes its size in sectors, rounded up; the running total saturates.
  assign new_len  = 22'(request.size_bytes >> SectShift)
                  + 22'(|(request.size_bytes & SectMask));
  assign fs_sum   = 31'(file_span) + 31'(new_len);
  assign fs_next  = (fs_sum > 31'(Cap30)) ? Cap30 : fs_sum[29:0];
  assign full     = (entries_used >= CntMax);
  assign wr_idx   = entries_used[IdxW-1:0];
  assign last_idx = IdxW'(entries_used - CntW'(1));

  assign wr_en = cmd.accept && (request.opcode == OP_ADD) && !full;
  always_comb begin
    wr_data.is_dir = request.is_dir;
    wr_data.start  = request.is_dir ? 30'(dirs_used) : file_span;
    wr_data.len    = request.is_dir ? 22'd1 : new_len;
  end

  // Entry 0 is always the root and is never written, so it reads as a constant.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rdata <= mem[scan_idx];
  end

  assign cur      = (rd_idx == '0) ? RootEntry : rdata;
  assign diff     = {1'b0, key} - {1'b0, cur.start};
  assign hit_dir  = cur.is_dir && (cur.start == key);
  assign hit_file = !cur.is_dir && !diff[30] && (diff[29:0] < 30'(cur.len));

  always_comb begin
    status.need_scan = (request.opcode == OP_LOOKUP)
                     && ((lk_region == REGION_DIR) || (lk_region == REGION_FILE));
    status.hit       = rd_vld && (key_is_dir ? hit_dir : hit_file);
    status.last      = rd_vld && (rd_idx == last_idx);
  end

  // Table counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= CntW'(1);
      dirs_used    <= CntW'(1);
      file_span    <= '0;
    end else if (cmd.accept) begin
      case (request.opcode)
        OP_CLEAR: begin
          entries_used <= CntW'(1);
          dirs_used    <= CntW'(1);
          file_span    <= '0;
        end
        OP_ADD: begin
          if (!full) begin
            entries_used <= entries_used + CntW'(1);
            if (request.is_dir) begin
              dirs_used <= dirs_used + CntW'(1);
            end else begin
              file_span <= fs_next;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scan pointer: one memory read per cycle, compared in the cycle after the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (cmd.accept) begin
      rd_vld <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      rd_idx <= scan_idx;
      if (scan_idx != last_idx) begin
        scan_idx <= scan_idx + IdxW'(1);
      end
    end
  end

  // Result register and lookup key.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= (request.opcode == OP_ADD) && full;
      res_region <= (request.opcode == OP_LOOKUP) ? lk_region : REGION_ZEROS;
      res_index  <= ((request.opcode == OP_ADD) && !full) ? 8'(entries_used) : 8'd0;
      res_offset <= '0;
      key_is_dir <= (lk_region == REGION_DIR);
      if (lk_region == REGION_DIR) begin
        key <= 30'(request.sector_addr - SectDir0);
      end else begin
        key <= 30'(request.sector_addr - 32'(file_base));
      end
    end else if (cmd.finish && status.hit) begin
      res_index  <= 8'(rd_idx);
      res_offset <= key_is_dir ? 21'd0 : 21'(diff);
    end
  end

  always_comb begin
    result.status      = res_status;
    result.region      = res_region;
    result.entry_index = res_index;
    result.file_offset = res_offset;
    result.image_size  = total_sat;
  end

endmodule

// ----- sv/disc_sector_extent_mapper.sv -----
// Top level of the disc sector extent mapper: controller plus datapath.
// Depends on dsem_pkg, dsem_ctrl and dsem_datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------
//   command  | start, busy        | request (req_t)
//   result   | done (one cycle)   | result (rsp_t)
//
// Clear, add and lookups outside the directory and file regions give their
// result in the cycle after the transaction is taken.
// Directory and file lookups scan the entry table through its single read
// port, one entry a cycle, with busy high meanwhile.
// Reset restores the root-only table at once; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module disc_sector_extent_mapper import dsem_pkg::*; #(
  parameter int MaxEntries = MaxEntriesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dsem_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dsem_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .result  (result)
  );

endmodule

// ----- sv/dsem_checker.sv -----
// Port-level checker for the disc sector extent mapper, bound to the top.
// Depends on dsem_pkg and disc_sector_extent_mapper_assert.svh.
`include "disc_sector_extent_mapper_assert.svh"

module dsem_checker import dsem_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input req_t request,
  input rsp_t result
);

  `DSEM_ASSERT_NXT(a_quick_op, start && !busy && (request.opcode != OP_LOOKUP), done && !busy, "non-lookup transaction did not answer next cycle")
  `DSEM_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
  `DSEM_ASSERT_IMP(a_full_fields, done && result.status, (result.region == REGION_ZEROS) && (result.entry_index == 8'd0), "table-full result carries region or index")
  `DSEM_ASSERT_IMP(a_offset_zero, done && (result.region != REGION_DIR) && (result.region != REGION_FILE), result.file_offset == 21'd0, "offset set outside the directory and file regions")

endmodule

bind disc_sector_extent_mapper dsem_checker u_dsem_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .request (request),
  .result  (result)
);

// ----- tb/disc_sector_extent_mapper_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the disc sector extent mapper: a directed table,
// then random clears, adds and lookups, checked against pinned answers or a
// sector map predictor. Depends on dsem_pkg and disc_sector_extent_mapper.
module disc_sector_extent_mapper_test import dsem_pkg::*; ();

  localparam int MaxEntries = MaxEntriesDefault;
  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = MaxEntries + 8;
  // The package names three operations; the fourth code must be a no-op.
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  disc_sector_extent_mapper #(.MaxEntries(MaxEntries)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #6 clk = ~clk;

  // Predictor copy of the entry table.
  bit              map_is_dir [MaxEntries];
  longint unsigned map_first [MaxEntries];
  longint unsigned map_len [MaxEntries];
  int              map_entries;
  longint unsigned map_dirs;
  longint unsigned map_file_span;

  rsp_t pending_answers[$];
  bit   pin_valid = 1'b0;
  rsp_t pin_answer = '0;
  int   idle_pct = 0;
  int   errors = 0;
  int   answered = 0;
  int   cycles = 0;
  int   adds = 0;
  int   refused = 0;
  int   clears = 0;
  int   region_hits [8];

  typedef struct {
    req_t cmd;
    bit   pinned;
    rsp_t want;
  } plan_row_t;

  plan_row_t opening_plan[$];

  function automatic void map_clear();
    for (int i = 0; i < MaxEntries; i++) begin
      map_is_dir[i] = 1'b0;
      map_first[i] = 0;
      map_len[i] = 0;
    end
    map_is_dir[0] = 1'b1;
    map_len[0] = 1;
    map_entries = 1;
    map_dirs = 1;
    map_file_span = 0;
  endfunction

  function automatic longint unsigned map_total();
    longint unsigned t;
    t = 64'(SectDir0) + map_dirs + map_file_span;
    return (t > 64'(Cap30)) ? 64'(Cap30) : t;
  endfunction

  // Applies one command to the predicted table and returns the answer the
  // block must give for it.
  function automatic rsp_t mapper_answer(input req_t r);
    rsp_t a;
    longint unsigned sectors;
    longint unsigned file_base;
    longint unsigned addr;
    longint unsigned rel;
    longint unsigned sum;
    int idx;
    bit found;
    a = '0;
    found = 1'b0;
    addr = 64'(r.sector_addr);
    file_base = 64'(SectDir0) + map_dirs;
    case (r.opcode)
      OP_CLEAR: map_clear();
      OP_ADD: begin
        if (map_entries >= MaxEntries) begin
          a.status = 1'b1;
        end else begin
          idx = map_entries;
          map_is_dir[idx] = r.is_dir;
          if (r.is_dir) begin
            map_first[idx] = map_dirs;
            map_len[idx] = 1;
            map_dirs++;
          end else begin
            sectors = (64'(r.size_bytes) + 64'(SectMask)) >> SectShift;
            map_first[idx] = map_file_span;
            map_len[idx] = sectors;
            sum = map_file_span + sectors;
            map_file_span = (sum > 64'(Cap30)) ? 64'(Cap30) : sum;
          end
          map_entries++;
          a.entry_index = idx[7:0];
        end
      end
      OP_LOOKUP: begin
        if (addr < 64'(SectPvd)) begin
          a.region = REGION_ZEROS;
        end else if (addr == 64'(SectPvd)) begin
          a.region = REGION_PVD;
        end else if (addr == 64'(SectTerm)) begin
          a.region = REGION_TERM;
        end else if (addr == 64'(SectPathL)) begin
          a.region = REGION_PATH_L;
        end else if (addr == 64'(SectPathM)) begin
          a.region = REGION_PATH_M;
        end else if (addr < file_base && addr < map_total()) begin
          a.region = REGION_DIR;
          for (idx = 0; idx < map_entries; idx++) begin
            if (!found && map_is_dir[idx] && map_first[idx] == addr - 64'(SectDir0)) begin
              found = 1'b1;
              a.entry_index = idx[7:0];
            end
          end
        end else if (addr >= file_base && addr < map_total()) begin
          a.region = REGION_FILE;
          rel = addr - file_base;
          // The first file in table order whose extent covers the sector wins.
          for (idx = 0; idx < map_entries; idx++) begin
            if (!found && !map_is_dir[idx] && map_len[idx] != 0 &&
                rel >= map_first[idx] && rel < map_first[idx] + map_len[idx]) begin
              found = 1'b1;
              a.entry_index = idx[7:0];
              a.file_offset = 21'(rel - map_first[idx]);
            end
          end
        end else begin
          a.region = REGION_BEYOND;
        end
      end
      default: ;
    endcase
    a.image_size = 30'(map_total());
    return a;
  endfunction

  function automatic logic [31:0] pick_file_size();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'($urandom_range(10000, 1));
      2: return 32'($urandom_range(64, 1)) * 32'd2048 - 32'd1 + 32'($urandom_range(2));
      3: return $urandom;
      4: return 32'hFFFF_FFFF - 32'($urandom_range(4096));
      default: return 32'($urandom_range(2047, 1));
    endcase
  endfunction

  // Lookup addresses aimed mostly at entries and region borders of the
  // current table, with some fully random ones.
  function automatic logic [31:0] pick_sector();
    longint unsigned file_base;
    longint unsigned total;
    int i;
    file_base = 64'(SectDir0) + map_dirs;
    total = map_total();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'($urandom_range(19));
      2, 3, 4: begin
        i = $urandom_range(map_entries - 1);
        if (map_is_dir[i]) return 32'(64'(SectDir0) + map_first[i]);
        if (map_len[i] == 0) return 32'(file_base + map_first[i]);
        return 32'(file_base + map_first[i] + 64'($urandom_range(32'(map_len[i] - 1))));
      end
      5: return 32'($urandom_range(32'(total + 2)));
      6: begin
        case ($urandom_range(3))
          0: return 32'(file_base - 1);
          1: return 32'(file_base);
          2: return 32'(total - 1);
          default: return 32'(total);
        endcase
      end
      7: return 32'(64'(SectDir0) + 64'($urandom_range(32'(map_dirs - 1))));
      8: return 32'(total) + $urandom;
      default: return {2'b11, 30'($urandom)};
    endcase
  endfunction

  function automatic req_t random_command(input int add_pct, input bit allow_clear);
    req_t r;
    int roll;
    roll = $urandom_range(99);
    r.is_dir = 1'($urandom);
    r.size_bytes = $urandom;
    r.sector_addr = $urandom;
    if (allow_clear && roll < 2) begin
      r.opcode = OP_CLEAR;
    end else if (roll < 4) begin
      r.opcode = OpUnused;
    end else if (roll < 4 + add_pct) begin
      r.opcode = OP_ADD;
      r.is_dir = ($urandom_range(99) < 35);
      if (!r.is_dir) r.size_bytes = pick_file_size();
    end else begin
      r.opcode = OP_LOOKUP;
      r.sector_addr = pick_sector();
    end
    return r;
  endfunction

  task automatic plan_row(input logic [1:0] op, input logic dir, input logic [31:0] size,
                          input logic [31:0] addr, input bit pinned, input logic st,
                          input logic [2:0] rgn, input logic [7:0] idx,
                          input logic [29:0] total);
    plan_row_t row;
    row.cmd = '{opcode: op, is_dir: dir, size_bytes: size, sector_addr: addr};
    row.pinned = pinned;
    row.want = '{status: st, region: rgn, entry_index: idx, file_offset: 21'd0,
                 image_size: total};
    opening_plan.push_back(row);
  endtask

  // Offers one transaction after a random idle gap and returns once it is taken.
  task automatic issue(input req_t r, input bit pinned, input rsp_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    pin_valid = pinned;
    pin_answer = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_run(input int count, input int add_pct, input bit allow_clear);
    for (int n = 0; n < count; n++) begin
      issue(random_command(add_pct, allow_clear), 1'b0, '0);
    end
  endtask

  // Results are checked before the transaction taken at the same edge is
  // predicted, since no result can come in the cycle its command is taken.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction pending: %p", $time, result);
        end else begin
          want = pending_answers.pop_front();
          answered++;
          if (result !== want) begin
            errors++;
            $display("%0t: result %0d expected status=%0d region=%0d index=%0d offset=%0d total=%0d",
                     $time, answered, want.status, want.region, want.entry_index,
                     want.file_offset, want.image_size);
            $display("%0t: result %0d actual   status=%0d region=%0d index=%0d offset=%0d total=%0d",
                     $time, answered, result.status, result.region, result.entry_index,
                     result.file_offset, result.image_size);
          end
        end
      end
      if (start && !busy) begin
        want = mapper_answer(request);
        case (request.opcode)
          OP_CLEAR: clears++;
          OP_ADD: begin
            adds++;
            if (want.status) refused++;
          end
          OP_LOOKUP: region_hits[want.region]++;
          default: ;
        endcase
        if (pin_valid) want = pin_answer;
        pending_answers.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("disc_sector_extent_mapper verification failed");
      $finish;
    end
  end

  initial begin
    map_clear();
    foreach (region_hits[i]) region_hits[i] = 0;

    // Reset state, fixed sectors and region borders of the root-only table.
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b1, 32'hFFFF_FFFF, 32'd15, 1'b1, 1'b0, REGION_ZEROS, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd16, 1'b1, 1'b0, REGION_PVD, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd17, 1'b1, 1'b0, REGION_TERM, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd18, 1'b1, 1'b0, REGION_PATH_L, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd19, 1'b1, 1'b0, REGION_PATH_M, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd20, 1'b1, 1'b0, REGION_DIR, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd21, 1'b1, 1'b0, REGION_BEYOND, 8'd0, 30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, REGION_BEYOND, 8'd0, 30'd21);
    plan_row(OpUnused, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, REGION_ZEROS, 8'd0,
             30'd21);
    // Adds: a directory ignores its size, empty files take no sector.
    plan_row(OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd1, 30'd22);
    plan_row(OP_ADD, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd2, 30'd22);
    plan_row(OP_ADD, 1'b0, 32'd1, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd3, 30'd23);
    plan_row(OP_ADD, 1'b0, 32'd2048, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd4, 30'd24);
    plan_row(OP_ADD, 1'b0, 32'd2049, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd5, 30'd26);
    plan_row(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, REGION_ZEROS, 8'd6,
             30'd2097178);
    plan_row(OP_ADD, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, REGION_ZEROS, 8'd7,
             30'd2097179);
    // A late directory moves the file area; these go to the predictor.
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd22, 1'b0, 1'b0, REGION_ZEROS, 8'd0, 30'd0);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd23, 1'b0, 1'b0, REGION_ZEROS, 8'd0, 30'd0);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd26, 1'b0, 1'b0, REGION_ZEROS, 8'd0, 30'd0);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd2097178, 1'b0, 1'b0, REGION_ZEROS, 8'd0, 30'd0);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd2097179, 1'b0, 1'b0, REGION_ZEROS, 8'd0, 30'd0);
    plan_row(OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, REGION_ZEROS, 8'd0,
             30'd21);
    plan_row(OP_LOOKUP, 1'b0, 32'd0, 32'd21, 1'b1, 1'b0, REGION_BEYOND, 8'd0, 30'd21);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_plan[i]) begin
      issue(opening_plan[i].cmd, opening_plan[i].pinned, opening_plan[i].want);
    end

    // Fill the table past capacity with lookups in between, then mix freely.
    idle_pct = 0;
    issue('{opcode: OP_CLEAR, is_dir: 1'b0, size_bytes: 32'd0, sector_addr: 32'd0},
          1'b0, '0);
    random_run(320, 80, 1'b0);
    random_run(150, 40, 1'b1);
    idle_pct = 83;
    random_run(350, 45, 1'b1);
    idle_pct = 31;
    random_run(450, 45, 1'b1);

    @(negedge clk);
    start <= 1'b0;
    pin_valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d results: %0d adds (%0d refused on a full table), %0d clears.",
             answered, adds, refused, clears);
    $display("Lookups by region, zeros to beyond end: %0d %0d %0d %0d %0d %0d %0d %0d.",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6], region_hits[7]);
    if (errors == 0) begin
      $display("disc_sector_extent_mapper verification clean");
    end else begin
      $display("disc_sector_extent_mapper verification failed");
    end
    $finish;
  end

endmodule
